// File: src/tmce_pkg.sv
// ----------------------------------------------------------------------------
// tmce_pkg: shared types and constants for the trimmed-mean EMA filter
// Sample widths, register indexes and reset values, and the config struct
// that the register bank hands to the update engine.
// ----------------------------------------------------------------------------
package tmce_pkg;

    localparam int SAMPLE_W           = 12;
    localparam int SHIFT_W            = 4;
    localparam int COUNT_W            = 32;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 12;
    localparam int DEFAULT_HALF_BLOCK = 32;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_CLAMP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_SHIFT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DWELL_SHIFT = 2'd2;

    localparam logic [SAMPLE_W-1:0] STEP_CLAMP_RST  = 12'd20;
    localparam logic [SHIFT_W-1:0]  FAST_SHIFT_RST  = 4'd2;
    localparam logic [SHIFT_W-1:0]  DWELL_SHIFT_RST = 4'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] step_clamp;
        logic [SHIFT_W-1:0]  fast_shift;
        logic [SHIFT_W-1:0]  dwell_shift;
    } cfg_t;

endpackage

// File: src/tmce_front.sv
// ----------------------------------------------------------------------------
// tmce_front: per-block accumulator
// Keeps running sum, min and max per axis; on the last sample of a block it
// pushes the finished block statistics into the queue and restarts.
// ----------------------------------------------------------------------------
module tmce_front #(
    parameter int HALF_BLOCK = tmce_pkg::DEFAULT_HALF_BLOCK,
    parameter int SUM_W      = tmce_pkg::SAMPLE_W + $clog2(HALF_BLOCK),
    parameter int ENTRY_W    = 2 * (SUM_W + 2 * tmce_pkg::SAMPLE_W)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmce_pkg::SAMPLE_W-1:0] s_sample_x,
    input  logic [tmce_pkg::SAMPLE_W-1:0] s_sample_y,
    output logic                          q_push,
    output logic [ENTRY_W-1:0]            q_data,
    input  logic                          q_full
);

    localparam int POS_W = $clog2(HALF_BLOCK);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HALF_BLOCK - 1);

    logic [SUM_W-1:0]              sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic [tmce_pkg::SAMPLE_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [tmce_pkg::SAMPLE_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic [POS_W-1:0]              pos_reg;
    logic                          accept, last;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign last    = (pos_reg == LAST_POS);

    assign sum_x_next = sum_x_reg + SUM_W'(s_sample_x);
    assign sum_y_next = sum_y_reg + SUM_W'(s_sample_y);
    assign min_x_next = (s_sample_x < min_x_reg) ? s_sample_x : min_x_reg;
    assign max_x_next = (s_sample_x > max_x_reg) ? s_sample_x : max_x_reg;
    assign min_y_next = (s_sample_y < min_y_reg) ? s_sample_y : min_y_reg;
    assign max_y_next = (s_sample_y > max_y_reg) ? s_sample_y : max_y_reg;

    assign q_push = accept && last;
    assign q_data = {sum_x_next, min_x_next, max_x_next,
                     sum_y_next, min_y_next, max_y_next};

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last)) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            min_x_reg <= tmce_pkg::SAMPLE_MAX;
            max_x_reg <= '0;
            min_y_reg <= tmce_pkg::SAMPLE_MAX;
            max_y_reg <= '0;
            pos_reg   <= '0;
        end else if (accept) begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            pos_reg   <= pos_reg + POS_W'(1);
        end
    end

endmodule

// File: src/tmce_fifo.sv
// ----------------------------------------------------------------------------
// tmce_fifo: short queue of finished block statistics
// Register-based, power-of-two depth, show-ahead read.
// ----------------------------------------------------------------------------
module tmce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tmce_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> out_valid)
        else $error("pop from empty queue");

endmodule

// File: src/tmce_back.sv
// ----------------------------------------------------------------------------
// tmce_back: block mean and slew-limited EMA engine
// Trim, reciprocal multiply, then mean plus four EMA updates into the output
// register. Three stages with a valid/ready chain back to the queue.
// ----------------------------------------------------------------------------
module tmce_back #(
    parameter int HALF_BLOCK = tmce_pkg::DEFAULT_HALF_BLOCK,
    parameter int SUM_W      = tmce_pkg::SAMPLE_W + $clog2(HALF_BLOCK),
    parameter int ENTRY_W    = 2 * (SUM_W + 2 * tmce_pkg::SAMPLE_W)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tmce_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    input  logic [ENTRY_W-1:0]            q_data,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tmce_pkg::SAMPLE_W-1:0] m_mean_x,
    output logic [tmce_pkg::SAMPLE_W-1:0] m_mean_y,
    output logic [tmce_pkg::SAMPLE_W-1:0] m_fast_x,
    output logic [tmce_pkg::SAMPLE_W-1:0] m_fast_y,
    output logic [tmce_pkg::SAMPLE_W-1:0] m_dwell_x,
    output logic [tmce_pkg::SAMPLE_W-1:0] m_dwell_y,
    output logic [tmce_pkg::COUNT_W-1:0]  m_samples_seen
);

    localparam int SW       = tmce_pkg::SAMPLE_W;
    localparam int DIVISOR  = HALF_BLOCK - 2;
    // exact floor(n / DIVISOR) for n < 2^SUM_W via ceil(2^S / DIVISOR)
    localparam int RSHIFT   = SUM_W + $clog2(DIVISOR);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // arithmetic right shift of the clamped difference, toward minus infinity
    function automatic logic [SW-1:0] slew(input logic [SW-1:0]          avg,
                                           input logic [SW-1:0]          mean,
                                           input logic [SW-1:0]          clamp,
                                           input logic [tmce_pkg::SHIFT_W-1:0] sh);
        logic          up;
        logic [SW-1:0] mag, lim, step, lost;
        up   = (mean >= avg);
        mag  = up ? (mean - avg) : (avg - mean);
        lim  = (mag > clamp) ? clamp : mag;
        step = lim >> sh;
        lost = lim & ~({SW{1'b1}} << sh);
        return up ? (avg + step) : (avg - step - SW'(|lost));
    endfunction

    logic [SUM_W-1:0] q_sum_x, q_sum_y;
    logic [SW-1:0]    q_min_x, q_max_x, q_min_y, q_max_y;

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3, adv3;
    logic [SUM_W-1:0]  num_x_reg, num_y_reg;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [SW-1:0]     mean_x_next, mean_y_next;
    logic [SW-1:0]     mean_x_reg, mean_y_reg;
    logic [SW-1:0]     fast_x_reg, fast_y_reg, dwell_x_reg, dwell_y_reg;
    logic [tmce_pkg::COUNT_W-1:0] total_reg;
    logic              primed_reg;

    assign {q_sum_x, q_min_x, q_max_x, q_sum_y, q_min_y, q_max_y} = q_data;

    assign rdy3  = !v3_reg || m_ready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign q_pop = q_valid && rdy1;
    assign adv3  = v2_reg && rdy3;

    assign mean_x_next = prod_x_reg[RSHIFT +: SW];
    assign mean_y_next = prod_y_reg[RSHIFT +: SW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= q_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // trim and divide
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            num_x_reg <= q_sum_x - SUM_W'(q_min_x) - SUM_W'(q_max_x);
            num_y_reg <= q_sum_y - SUM_W'(q_min_y) - SUM_W'(q_max_y);
        end
        if (v1_reg && rdy2) begin
            prod_x_reg <= PROD_W'(num_x_reg) * PROD_W'(RECIP);
            prod_y_reg <= PROD_W'(num_y_reg) * PROD_W'(RECIP);
        end
        if (adv3) begin
            mean_x_reg <= mean_x_next;
            mean_y_reg <= mean_y_next;
        end
    end

    // averages and sample count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_x_reg  <= '0;
            fast_y_reg  <= '0;
            dwell_x_reg <= '0;
            dwell_y_reg <= '0;
            total_reg   <= '0;
            primed_reg  <= 1'b0;
        end else if (adv3) begin
            if (!primed_reg) begin
                fast_x_reg  <= mean_x_next;
                fast_y_reg  <= mean_y_next;
                dwell_x_reg <= mean_x_next;
                dwell_y_reg <= mean_y_next;
            end else begin
                fast_x_reg  <= slew(fast_x_reg, mean_x_next, cfg.step_clamp, cfg.fast_shift);
                fast_y_reg  <= slew(fast_y_reg, mean_y_next, cfg.step_clamp, cfg.fast_shift);
                dwell_x_reg <= slew(dwell_x_reg, mean_x_next, cfg.step_clamp,
                                    cfg.dwell_shift);
                dwell_y_reg <= slew(dwell_y_reg, mean_y_next, cfg.step_clamp,
                                    cfg.dwell_shift);
            end
            primed_reg <= 1'b1;
            total_reg  <= total_reg + tmce_pkg::COUNT_W'(HALF_BLOCK);
        end
    end

    assign m_valid        = v3_reg;
    assign m_mean_x       = mean_x_reg;
    assign m_mean_y       = mean_y_reg;
    assign m_fast_x       = fast_x_reg;
    assign m_fast_y       = fast_y_reg;
    assign m_dwell_x      = dwell_x_reg;
    assign m_dwell_y      = dwell_y_reg;
    assign m_samples_seen = total_reg;

    a_primed_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> primed_reg)
        else $error("result shown before averages were loaded");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        adv3 |=> (total_reg == $past(total_reg) + tmce_pkg::COUNT_W'(HALF_BLOCK)))
        else $error("sample count did not advance by one block");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv3 |=> ($stable(total_reg) && $stable(fast_x_reg) && $stable(dwell_y_reg)))
        else $error("average state moved without a block");

endmodule

// File: src/trimmed_mean_clamped_ema_filter.sv
// ----------------------------------------------------------------------------
// trimmed_mean_clamped_ema_filter: block trimmed mean with slew-limited EMAs
// Input beats carry one X/Y converter sample pair (s_ channel, valid/ready).
// Every HALF_BLOCK beats the block closes: per axis the sum less the min and
// max is divided by HALF_BLOCK-2 (truncating) to give the trimmed mean. The
// first block loads the fast and dwell averages with that mean; later blocks
// move each average by the difference clamped to +/- step_clamp and shifted
// right (floor) by fast_shift or dwell_shift. One result beat (m_ channel)
// leaves per block, carrying means, averages and the finished sample count.
// Throughput: one input beat per cycle. s_ready only drops when the
// block queue (QUEUE_DEPTH entries) is full because m_ready is held low.
// A block's result passes the queue and the trim, multiply and update
// registers before it shows on m_valid. The m_ stage is a register,
// so a stalled receiver just holds the current result beat.
// Reset (aresetn low, synchronous): registers go to 20/2/4, the block and the
// averages clear, queue and pipeline empty. Config writes (cfg_wr_en) are
// registered; indexes past dwell_shift are dropped.
// ----------------------------------------------------------------------------
module trimmed_mean_clamped_ema_filter #(
    parameter int HALF_BLOCK = tmce_pkg::DEFAULT_HALF_BLOCK
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config
    input  logic                             cfg_wr_en,
    input  logic [tmce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tmce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample beats
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tmce_pkg::SAMPLE_W-1:0]    s_sample_x,
    input  logic [tmce_pkg::SAMPLE_W-1:0]    s_sample_y,
    // result beats
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tmce_pkg::SAMPLE_W-1:0]    m_mean_x,
    output logic [tmce_pkg::SAMPLE_W-1:0]    m_mean_y,
    output logic [tmce_pkg::SAMPLE_W-1:0]    m_fast_x,
    output logic [tmce_pkg::SAMPLE_W-1:0]    m_fast_y,
    output logic [tmce_pkg::SAMPLE_W-1:0]    m_dwell_x,
    output logic [tmce_pkg::SAMPLE_W-1:0]    m_dwell_y,
    output logic [tmce_pkg::COUNT_W-1:0]     m_samples_seen
);

    // block sum needs log2(HALF_BLOCK) bits of headroom over a sample
    localparam int SUM_W   = tmce_pkg::SAMPLE_W + $clog2(HALF_BLOCK);
    // queue entry: sum, min, max for each axis
    localparam int ENTRY_W = 2 * (SUM_W + 2 * tmce_pkg::SAMPLE_W);

    tmce_pkg::cfg_t     cfg_reg;
    logic               q_push, q_full, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    // register bank; shift registers keep the low nibble of the write data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_clamp  <= tmce_pkg::STEP_CLAMP_RST;
            cfg_reg.fast_shift  <= tmce_pkg::FAST_SHIFT_RST;
            cfg_reg.dwell_shift <= tmce_pkg::DWELL_SHIFT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tmce_pkg::REG_STEP_CLAMP: begin
                    cfg_reg.step_clamp <= cfg_wdata;
                end
                tmce_pkg::REG_FAST_SHIFT: begin
                    cfg_reg.fast_shift <= cfg_wdata[tmce_pkg::SHIFT_W-1:0];
                end
                tmce_pkg::REG_DWELL_SHIFT: begin
                    cfg_reg.dwell_shift <= cfg_wdata[tmce_pkg::SHIFT_W-1:0];
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // front: accumulate, push closed blocks
    tmce_front #(
        .HALF_BLOCK (HALF_BLOCK),
        .SUM_W      (SUM_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_x (s_sample_x),
        .s_sample_y (s_sample_y),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full)
    );

    // queue decouples the sample stream from a stalled result receiver
    tmce_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (tmce_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_rdata)
    );

    // back: trim, divide, update averages, hold result beat
    tmce_back #(
        .HALF_BLOCK (HALF_BLOCK),
        .SUM_W      (SUM_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mean_x       (m_mean_x),
        .m_mean_y       (m_mean_y),
        .m_fast_x       (m_fast_x),
        .m_fast_y       (m_fast_y),
        .m_dwell_x      (m_dwell_x),
        .m_dwell_y      (m_dwell_y),
        .m_samples_seen (m_samples_seen)
    );

endmodule

// File: bench/tb_trimmed_mean_clamped_ema_filter.sv
// ----------------------------------------------------------------------------
// tb_trimmed_mean_clamped_ema_filter: self-checking bench for the block filter
// Sample pairs go in on the s_ channel and block results come back on the m_
// channel. A tracker class keeps its own copy of the block sums, min/max, the
// fast and dwell averages and the registers. It queues one expected result
// per finished block and checks every result beat field by field. Phases step
// through register settings and sender/receiver idling, including a long
// receiver hold that backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_clamped_ema_filter;
    import tmce_pkg::*;

    localparam int HALF_BLOCK    = DEFAULT_HALF_BLOCK;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;    // margin for the result pipeline to empty
    localparam int TAIL_CYCLES   = 40;   // watch for stray beats at the end
    localparam int HOLD_CYCLES   = 400;  // long enough to fill the block queue

    // index past the last register; the block drops writes to it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // field order matches the m_ port order so a concat fills it
    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_x;
        logic [SAMPLE_W-1:0] mean_y;
        logic [SAMPLE_W-1:0] fast_x;
        logic [SAMPLE_W-1:0] fast_y;
        logic [SAMPLE_W-1:0] dwell_x;
        logic [SAMPLE_W-1:0] dwell_y;
        logic [COUNT_W-1:0]  seen;
    } block_result_t;

    // ------------------------------------------------------------------------
    // Tracker: mirrors the block state and holds the results still owed.
    // ------------------------------------------------------------------------
    class block_average_tracker;
        cfg_t                regs;
        logic [16:0]         sum_x, sum_y;
        logic [SAMPLE_W-1:0] min_x, max_x, min_y, max_y;
        int unsigned         position;
        logic [SAMPLE_W-1:0] fast_x, fast_y, dwell_x, dwell_y;
        bit                  primed;
        logic [COUNT_W-1:0]  total;
        block_result_t       pending_blocks[$];
        int                  errors;

        function new();
            regs.step_clamp  = STEP_CLAMP_RST;
            regs.fast_shift  = FAST_SHIFT_RST;
            regs.dwell_shift = DWELL_SHIFT_RST;
            fast_x  = '0;
            fast_y  = '0;
            dwell_x = '0;
            dwell_y = '0;
            primed  = 1'b0;
            total   = '0;
            errors  = 0;
            clear_block();
        endfunction

        function void clear_block();
            sum_x    = '0;
            sum_y    = '0;
            min_x    = SAMPLE_MAX;
            max_x    = '0;
            min_y    = SAMPLE_MAX;
            max_y    = '0;
            position = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEP_CLAMP:  regs.step_clamp  = data;
                REG_FAST_SHIFT:  regs.fast_shift  = data[SHIFT_W-1:0];
                REG_DWELL_SHIFT: regs.dwell_shift = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] trim_mean(input logic [16:0] sum,
                                                input logic [SAMPLE_W-1:0] lo,
                                                input logic [SAMPLE_W-1:0] hi);
            return SAMPLE_W'((sum - lo - hi) / (HALF_BLOCK - 2));
        endfunction

        // move avg toward mean by the clamped difference, shifted (floor)
        function logic [SAMPLE_W-1:0] slew(input logic [SAMPLE_W-1:0] avg,
                                           input logic [SAMPLE_W-1:0] mean,
                                           input logic [SHIFT_W-1:0] shift);
            logic [SAMPLE_W-1:0] mag;
            logic [16:0]         biased;
            if (mean >= avg) begin
                mag = mean - avg;
                if (mag > regs.step_clamp) mag = regs.step_clamp;
                return avg + SAMPLE_W'(mag >> shift);
            end
            mag = avg - mean;
            if (mag > regs.step_clamp) mag = regs.step_clamp;
            // negative step floors, so round the magnitude up
            biased = 17'(mag) + ((17'd1 << shift) - 17'd1);
            return avg - SAMPLE_W'(biased >> shift);
        endfunction

        function void take_sample(input logic [SAMPLE_W-1:0] x,
                                  input logic [SAMPLE_W-1:0] y);
            block_result_t r;
            sum_x = sum_x + x;
            sum_y = sum_y + y;
            if (x < min_x) min_x = x;
            if (x > max_x) max_x = x;
            if (y < min_y) min_y = y;
            if (y > max_y) max_y = y;
            position++;
            if (position < HALF_BLOCK) return;

            r.mean_x = trim_mean(sum_x, min_x, max_x);
            r.mean_y = trim_mean(sum_y, min_y, max_y);
            clear_block();
            if (!primed) begin
                fast_x  = r.mean_x;
                fast_y  = r.mean_y;
                dwell_x = r.mean_x;
                dwell_y = r.mean_y;
                primed  = 1'b1;
            end else begin
                fast_x  = slew(fast_x, r.mean_x, regs.fast_shift);
                fast_y  = slew(fast_y, r.mean_y, regs.fast_shift);
                dwell_x = slew(dwell_x, r.mean_x, regs.dwell_shift);
                dwell_y = slew(dwell_y, r.mean_y, regs.dwell_shift);
            end
            total     = total + HALF_BLOCK;
            r.fast_x  = fast_x;
            r.fast_y  = fast_y;
            r.dwell_x = dwell_x;
            r.dwell_y = dwell_y;
            r.seen    = total;
            pending_blocks.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(input string name, input int unsigned blk,
                           input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("block %0d %s: got %0d, want %0d",
                                          blk, name, got, want));
        endtask

        task check_block(input block_result_t got);
            block_result_t want;
            int unsigned   blk;
            if (pending_blocks.size() == 0) begin
                report_mismatch("result beat with no block pending");
                return;
            end
            want = pending_blocks.pop_front();
            blk  = want.seen / HALF_BLOCK;
            compare_field("mean_x",  blk, 32'(got.mean_x),  32'(want.mean_x));
            compare_field("mean_y",  blk, 32'(got.mean_y),  32'(want.mean_y));
            compare_field("fast_x",  blk, 32'(got.fast_x),  32'(want.fast_x));
            compare_field("fast_y",  blk, 32'(got.fast_y),  32'(want.fast_y));
            compare_field("dwell_x", blk, 32'(got.dwell_x), 32'(want.dwell_x));
            compare_field("dwell_y", blk, 32'(got.dwell_y), 32'(want.dwell_y));
            compare_field("samples_seen", blk, got.seen, want.seen);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_sample_x;
    logic [SAMPLE_W-1:0]    s_sample_y;
    logic                   m_valid;
    logic                   m_ready;
    logic [SAMPLE_W-1:0]    m_mean_x;
    logic [SAMPLE_W-1:0]    m_mean_y;
    logic [SAMPLE_W-1:0]    m_fast_x;
    logic [SAMPLE_W-1:0]    m_fast_y;
    logic [SAMPLE_W-1:0]    m_dwell_x;
    logic [SAMPLE_W-1:0]    m_dwell_y;
    logic [COUNT_W-1:0]     m_samples_seen;

    trimmed_mean_clamped_ema_filter #(
        .HALF_BLOCK(HALF_BLOCK)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_x      (m_mean_x),
        .m_mean_y      (m_mean_y),
        .m_fast_x      (m_fast_x),
        .m_fast_y      (m_fast_y),
        .m_dwell_x     (m_dwell_x),
        .m_dwell_y     (m_dwell_y),
        .m_samples_seen(m_samples_seen)
    );

    always #5 aclk = ~aclk;

    block_average_tracker tracker;

    // idling knobs, in percent, set per phase by the stimulus
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // receiver hold-off: the stimulus raises the request, the receiver counts
    bit hold_request = 1'b0;
    int hold_left    = 0;

    // per-block signal shape for the random beats
    int beats_sent = 0;
    int level_x    = 2048;
    int level_y    = 1024;
    int spread     = 40;

    int cycle_count = 0;

    // ------------------------------------------------------------------------
    // Receiver: m_ready changes on the falling edge only.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = (int'($urandom_range(0, 99)) >= sink_stall_pct);
        end
    end

    // Result monitor: a beat moves on a rising edge with m_valid and m_ready.
    always @(posedge aclk) begin : result_monitor
        block_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_mean_x, m_mean_y, m_fast_x, m_fast_y,
                   m_dwell_x, m_dwell_y, m_samples_seen};
            tracker.check_block(got);
        end
    end

    // Watchdog: a hang or a missing result ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_trimmed_mean_clamped_ema_filter failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function logic [SAMPLE_W-1:0] clip12(input int v);
        if (v < 0) return '0;
        if (v > 4095) return SAMPLE_MAX;
        return v[SAMPLE_W-1:0];
    endfunction

    // mostly near the block level; now and then a full-range outlier that
    // the trim should throw away
    function logic [SAMPLE_W-1:0] pick_sample(input int level);
        if ($urandom_range(0, 15) == 0) return SAMPLE_W'($urandom_range(0, 4095));
        return clip12(level + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // One input beat. Starts and ends on a falling edge; valid holds until taken.
    task send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
        while (int'($urandom_range(0, 99)) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_sample_x = x;
        s_sample_y = y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_sample(x, y);
        beats_sent++;
        @(negedge aclk);
    endtask

    task run_phase(input int n_beats, input int src_pct, input int sink_pct);
        int k;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (k = 0; k < n_beats; k++) begin
            // new block: jump the level now and then, else let it drift
            if (beats_sent % HALF_BLOCK == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    level_x = int'($urandom_range(0, 4095));
                    level_y = int'($urandom_range(0, 4095));
                end else begin
                    level_x = int'(clip12(level_x + int'($urandom_range(0, 400)) - 200));
                    level_y = int'(clip12(level_y + int'($urandom_range(0, 400)) - 200));
                end
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 4;
                    2:       spread = 60;
                    default: spread = 600;
                endcase
            end
            send_sample(pick_sample(level_x), pick_sample(level_y));
        end
        s_valid = 1'b0;
    endtask

    // Block idle: nothing owed, and the pipe has had time to empty.
    task wait_drained();
        while (tracker.pending_blocks.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task apply_settings(input logic [SAMPLE_W-1:0] clamp,
                        input logic [SHIFT_W-1:0] fast,
                        input logic [SHIFT_W-1:0] dwell);
        wait_drained();
        write_reg(REG_STEP_CLAMP, clamp);
        write_reg(REG_FAST_SHIFT, CFG_DATA_W'(fast));
        write_reg(REG_DWELL_SHIFT, CFG_DATA_W'(dwell));
        cfg_wr_en = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [SAMPLE_W-1:0] corner [8];
        int i;
        corner = '{12'h000, 12'hFFF, 12'hAAA, 12'h555,
                   12'h001, 12'h800, 12'hFFE, 12'h7FF};

        tracker    = new();
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_STEP_CLAMP;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_sample_x = '0;
        s_sample_y = '0;
        m_ready    = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes and alternating bit patterns, back to back.
        // They open the first block, whose mean primes the averages.
        for (i = 0; i < 24; i++)
            send_sample(corner[i % 8], corner[(3 * i + 1) % 8]);

        // Reset register values, no idling.
        run_phase(176, 0, 0);

        // Widest clamp, no fast shift (fast tracks the mean), max dwell shift;
        // sender idles a lot.
        apply_settings(12'd4095, 4'd0, 4'd15);
        run_phase(250, 58, 0);

        // Zero clamp freezes both averages; receiver stalls a lot.
        apply_settings(12'd0, 4'd15, 4'd0);
        run_phase(160, 0, 58);

        // Mid settings, both sides idle now and then.
        apply_settings(12'd37, 4'd3, 4'd7);
        run_phase(250, 19, 19);

        // Back-pressure: receiver holds off while the sender keeps pushing,
        // so the block queue fills and s_ready has to drop.
        apply_settings(12'd300, 4'd1, 4'd5);
        hold_request = 1'b1;
        run_phase(288, 0, 0);

        // Clamp of one under the largest shift: steps of 0 up and -1 down.
        // A write to the spare index must not disturb anything.
        apply_settings(12'd1, 4'd15, 4'd15);
        write_reg(REG_SPARE, SAMPLE_MAX);
        cfg_wr_en = 1'b0;
        run_phase(160, 19, 19);

        // Random settings to finish.
        apply_settings(SAMPLE_W'($urandom_range(0, 4095)),
                       SHIFT_W'($urandom_range(0, 15)),
                       SHIFT_W'($urandom_range(0, 15)));
        run_phase(152, 19, 19);

        // Collect what is owed, then watch a while for stray result beats.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (tracker.errors == 0)
            $display("tb_trimmed_mean_clamped_ema_filter passed");
        else
            $display("tb_trimmed_mean_clamped_ema_filter failed");
        $finish;
    end

endmodule

// File: filelist.f
src/tmce_pkg.sv
src/tmce_front.sv
src/tmce_fifo.sv
src/tmce_back.sv
src/trimmed_mean_clamped_ema_filter.sv
bench/tb_trimmed_mean_clamped_ema_filter.sv
